/* rtl/core/dpfl_pkg.sv */
// Shared constants, types and helpers for the dated price floor lookup.
package dpfl_pkg;

    // Table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int AW          = $clog2(TABLE_DEPTH);
    localparam int CW          = $clog2(TABLE_DEPTH + 1);

    // Field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 7;
    localparam int DAY_W    = 7;
    localparam int PRICE_W  = 40;
    localparam int AMT_W    = 32;
    localparam int PROD_W   = 50;
    localparam int FMONTH_W = 4;
    localparam int FDAY_W   = 5;
    localparam int KEY_W    = YEAR_W + FMONTH_W + FDAY_W;
    localparam int ENTRY_W  = KEY_W + PRICE_W;
    localparam int IN_W     = YEAR_W + MONTH_W + DAY_W + PRICE_W + AMT_W;
    localparam int IN_TW    = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W    = PROD_W + YEAR_W + FMONTH_W + FDAY_W;
    localparam int OUT_TW   = ((OUT_W + 7) / 8) * 8;

    // Fixed point multiply: price split into high and low halves
    localparam int FRAC_BITS = 16;
    localparam int SPLIT     = 20;
    localparam int MA_W      = AMT_W - 1;
    localparam int PH_W      = PRICE_W - SPLIT;
    localparam int MP_W      = MA_W + ((PH_W > SPLIT) ? PH_W : SPLIT);
    localparam int FULL_W    = MA_W + PRICE_W + 1;

    localparam logic [63:0]     AMOUNT_MAX = 64'd1000 << FRAC_BITS;
    localparam logic [FULL_W-1:0] PROD_MAX = {{(FULL_W-PROD_W){1'b0}}, {PROD_W{1'b1}}};

    // Date checks
    localparam logic [YEAR_W-1:0] YEAR_MAX = YEAR_W'(9999);
    // 2^20/25 rounded up; y*DIV25_K mod 2^20 < DIV25_K exactly when y is a multiple of 25
    localparam int                DIV25_SH = 20;
    localparam logic [15:0]       DIV25_K  = 16'd41944;

    // Item kinds
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_BADDATE = 3'd1,
        ST_NEG     = 3'd2,
        ST_LARGE   = 3'd3,
        ST_NOPRICE = 3'd4,
        ST_FULL    = 3'd5
    } t_status;

    // Month lengths, February stretched in leap years
    function automatic logic [FDAY_W-1:0] month_days(input logic [FMONTH_W-1:0] m,
                                                     input logic leap);
        logic [FDAY_W-1:0] len;
        begin
            unique case (m)
                4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
                4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
                4'd2:    len = leap ? 5'd29 : 5'd28;
                default: len = 5'd0;
            endcase
            return len;
        end
    endfunction

endpackage

/* rtl/core/dated_price_floor_lookup.sv */
// Top level: date-sorted price table with floor lookup and fixed-point multiply.
//
//  channel   dir  handshake                  payload
//  s_axis    in   s_axis_tvalid/tready       tuser: op; tdata: year month day price amount
//  m_axis    out  m_axis_tvalid/tready       tuser: status; tdata: product found date
//
// One item at a time: accept, date check, binary search of ceil(log2(n+1)) probes
// (at most 11), decide, response. A query that finds a floor entry adds the split
// multiply (high half, low half, sum); an insert moves each entry above the insert
// point up one slot, then writes the new entry, via the single read and write port.
// Reset clears the state, the entry count and the output valid; the table memory needs no clearing pass.
// A result stalled on m_axis holds in the output register while the next beat is taken.
module dated_price_floor_lookup (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [dpfl_pkg::IN_TW-1:0]  s_axis_tdata,  // year, month, day, price, amount, pad
    input  logic                     s_axis_tuser,  // op
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [dpfl_pkg::OUT_TW-1:0] m_axis_tdata,  // product, found_year, found_month,
                                                       // found_day, pad
    output logic [2:0]               m_axis_tuser   // status
);
    import dpfl_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_CHECK  = 11'b000_0000_0010,
        S_SEARCH = 11'b000_0000_0100,
        S_DECIDE = 11'b000_0000_1000,
        S_SHIFT  = 11'b000_0001_0000,
        S_DRAIN  = 11'b000_0010_0000,
        S_INSERT = 11'b000_0100_0000,
        S_MULH   = 11'b000_1000_0000,
        S_MULL   = 11'b001_0000_0000,
        S_MULSUM = 11'b010_0000_0000,
        S_RESP   = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    // Table memory: key in the upper bits, price in the lower bits
    logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [ENTRY_W-1:0] r_rd;
    logic [AW-1:0]      rd_addr;
    logic               we;
    logic [AW-1:0]      wa;
    logic [ENTRY_W-1:0] wd;

    // Captured input beat
    logic                r_op;
    logic [YEAR_W-1:0]   r_year;
    logic [MONTH_W-1:0]  r_month;
    logic [DAY_W-1:0]    r_day;
    logic [PRICE_W-1:0]  r_price;
    logic [AMT_W-1:0]    r_amt;

    // Search and table control
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_lo, r_hi, r_mid, r_src;
    logic                r_hit;
    logic [ENTRY_W-1:0]  r_found;
    logic                r_wpend;
    logic [AW-1:0]       r_waddr;

    // Multiply and result
    logic [MP_W-1:0]     r_mhi, r_mlo;
    logic [PROD_W-1:0]   r_prod;
    t_status             r_status;

    // Output register
    logic                r_ovalid;
    logic [OUT_TW-1:0]   r_odata;
    logic [2:0]          r_ouser;

    logic [KEY_W-1:0]    key;
    logic [29:0]         y25;
    logic                div25, leap, date_ok;
    logic [FDAY_W-1:0]   mlen;
    logic [KEY_W-1:0]    rd_key;
    logic                go_right;
    logic [CW-1:0]       n_lo, n_hi, n_mid, start_mid;
    logic [MP_W-1:0]     mul_p;
    logic [FULL_W-1:0]   full, shifted;
    logic                in_fire, out_load;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_load = (r_state == S_RESP) && (!r_ovalid || m_axis_tready);

    assign key = {r_year, r_month[FMONTH_W-1:0], r_day[FDAY_W-1:0]};

    // Calendar check, leap year via divisibility by 4, 16 and 25
    assign y25     = 30'(r_year) * 30'(DIV25_K);
    assign div25   = y25[DIV25_SH-1:0] < 20'(DIV25_K);
    assign leap    = (r_year[1:0] == 2'd0) && (!div25 || (r_year[3:0] == 4'd0));
    assign mlen    = month_days(r_month[FMONTH_W-1:0], leap);
    assign date_ok = (r_year <= YEAR_MAX) && (r_month >= 7'd1) && (r_month <= 7'd12)
                     && (r_day >= 7'd1) && (r_day <= {2'b00, mlen});

    // Search step: lower bound on loads, upper bound on queries
    assign rd_key    = r_rd[ENTRY_W-1:PRICE_W];
    assign go_right  = (r_op == OP_QUERY) ? (rd_key <= key) : (rd_key < key);
    assign n_lo      = go_right ? (r_mid + CW'(1)) : r_lo;
    assign n_hi      = go_right ? r_hi : r_mid;
    assign n_mid     = n_lo + ((n_hi - n_lo) >> 1);
    assign start_mid = r_count >> 1;

    // Shared multiplier: amount times one half of the price
    assign mul_p   = MP_W'(r_amt[MA_W-1:0])
                     * MP_W'((r_state == S_MULH) ? r_found[PRICE_W-1:SPLIT]
                                                 : r_found[SPLIT-1:0]);
    assign full    = FULL_W'({r_mhi, {SPLIT{1'b0}}}) + FULL_W'(r_mlo);
    assign shifted = full >> FRAC_BITS;

    // Read address select
    always_comb begin
        rd_addr = '0;
        if (r_state == S_CHECK)       rd_addr = start_mid[AW-1:0];
        else if (r_state == S_SEARCH) rd_addr = n_mid[AW-1:0];
        else if (r_state == S_SHIFT)  rd_addr = r_src[AW-1:0];
    end

    // Write port select
    always_comb begin
        we = 1'b0;
        wa = r_waddr;
        wd = r_rd;
        if ((r_state == S_SHIFT) || (r_state == S_DRAIN)) begin
            we = r_wpend;
        end else if ((r_state == S_INSERT) || ((r_state == S_DECIDE) && (r_op == OP_LOAD)
                     && r_hit)) begin
            we = 1'b1;
            wa = r_lo[AW-1:0];
            wd = {key, r_price};
        end
    end

    // Memory
    always_ff @(posedge i_clk) begin
        if (we) mem[wa] <= wd;
        r_rd <= mem[rd_addr];
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_fire) n_state = S_CHECK;
            S_CHECK: begin
                if (!date_ok) n_state = S_RESP;
                else if ((r_op == OP_QUERY) && r_amt[AMT_W-1]) n_state = S_RESP;
                else if ((r_op == OP_QUERY) && ({32'd0, r_amt} > AMOUNT_MAX)) n_state = S_RESP;
                else if (r_count == '0) n_state = S_DECIDE;
                else n_state = S_SEARCH;
            end
            S_SEARCH: if (!(n_lo < n_hi)) n_state = S_DECIDE;
            S_DECIDE: begin
                if (r_op == OP_QUERY) begin
                    n_state = (r_lo == '0) ? S_RESP : S_MULH;
                end else if (r_hit || (r_count == CW'(TABLE_DEPTH))) begin
                    n_state = S_RESP;
                end else if (r_lo == r_count) begin
                    n_state = S_INSERT;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT:  if (r_src == r_lo) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_INSERT;
            S_INSERT: n_state = S_RESP;
            S_MULH:   n_state = S_MULL;
            S_MULL:   n_state = S_MULSUM;
            S_MULSUM: n_state = S_RESP;
            S_RESP:   if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INSERT) r_count <= r_count + CW'(1);
            if (out_load)            r_ovalid <= 1'b1;
            else if (m_axis_tready)  r_ovalid <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_op    <= s_axis_tuser;
            r_year  <= s_axis_tdata[YEAR_W-1:0];
            r_month <= s_axis_tdata[YEAR_W +: MONTH_W];
            r_day   <= s_axis_tdata[YEAR_W+MONTH_W +: DAY_W];
            r_price <= s_axis_tdata[YEAR_W+MONTH_W+DAY_W +: PRICE_W];
            r_amt   <= s_axis_tdata[YEAR_W+MONTH_W+DAY_W+PRICE_W +: AMT_W];
        end

        unique case (r_state)
            S_CHECK: begin
                r_lo    <= '0;
                r_hi    <= r_count;
                r_mid   <= start_mid;
                r_hit   <= 1'b0;
                r_wpend <= 1'b0;
                if (!date_ok)                                      r_status <= ST_BADDATE;
                else if ((r_op == OP_QUERY) && r_amt[AMT_W-1])     r_status <= ST_NEG;
                else if ((r_op == OP_QUERY) && ({32'd0, r_amt} > AMOUNT_MAX))
                    r_status <= ST_LARGE;
                else                                               r_status <= ST_OK;
            end
            S_SEARCH: begin
                r_lo  <= n_lo;
                r_hi  <= n_hi;
                r_mid <= n_mid;
                if (rd_key == key) r_hit <= 1'b1;
                // floor candidate: last probe at or below the query date
                if (go_right) r_found <= r_rd;
            end
            S_DECIDE: begin
                r_src <= r_count - CW'(1);
                if ((r_op == OP_QUERY) && (r_lo == '0)) r_status <= ST_NOPRICE;
                else if ((r_op == OP_LOAD) && !r_hit && (r_count == CW'(TABLE_DEPTH)))
                    r_status <= ST_FULL;
            end
            S_SHIFT: begin
                // read entry src now, write it one slot up next cycle
                r_wpend <= 1'b1;
                r_waddr <= AW'(r_src + CW'(1));
                r_src   <= r_src - CW'(1);
            end
            S_MULH:   r_mhi <= mul_p;
            S_MULL:   r_mlo <= mul_p;
            S_MULSUM: r_prod <= (shifted > PROD_MAX) ? PROD_MAX[PROD_W-1:0]
                                                     : shifted[PROD_W-1:0];
            default: ;
        endcase

        // Output register load: product, then year, month, day of the matched entry
        if (out_load) begin
            r_ouser <= r_status;
            if ((r_op == OP_QUERY) && (r_status == ST_OK)) begin
                r_odata <= OUT_TW'({r_found[PRICE_W +: FDAY_W],
                                    r_found[PRICE_W+FDAY_W +: FMONTH_W],
                                    r_found[PRICE_W+FDAY_W+FMONTH_W +: YEAR_W],
                                    r_prod});
            end else begin
                r_odata <= '0;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule

/* rtl/core/dpfl_checker.sv */
// Port-level checker for the dated price floor lookup, bound to the top level.
module dpfl_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [dpfl_pkg::OUT_TW-1:0] m_axis_tdata,
    input logic [2:0]                  m_axis_tuser
);
    import dpfl_pkg::*;

    // Output register empties on reset
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid right after reset");

    // Status stays within the defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= 3'(ST_FULL)))
        else $error("undefined status code");

    // Any non-ok result carries an all-zero payload
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != 3'(ST_OK))) |-> (m_axis_tdata == '0))
        else $error("payload nonzero on non-ok result");

    // Found month is a calendar month or zero
    a_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[PROD_W+YEAR_W +: FMONTH_W] <= 4'd12))
        else $error("found month out of range");

    // Stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result beat changed");

endmodule

bind dated_price_floor_lookup dpfl_checker u_dpfl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
